// ----- rtl/core/dqs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dqs_pkg
// Shared sizes, codes and state type of the deque with search unit.
// ----------------------------------------------------------------------------
package dqs_pkg;

  // ring store size and derived widths
  localparam int DEPTH   = 16;
  localparam int PTR_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int SUM_W   = PTR_W + 1;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 4;
  localparam int ACT_W   = 3;
  localparam int STAT_W  = 2;

  // request codes
  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_FIND       = 3'd4,
    ACT_READ_POS   = 3'd5
  } action_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_DONE      = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_READ = 2'd1,
    S_SCAN = 2'd2,
    S_FIN  = 2'd3
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/core/dqs_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dqs_if
// Request and result channels of the deque with search unit.
// ----------------------------------------------------------------------------

// request channel
interface dqs_in_if;
  logic                               valid;
  logic                               ready;
  logic [dqs_pkg::ACT_W-1:0]          action;
  logic signed [dqs_pkg::VALUE_W-1:0] item_value;
  logic [dqs_pkg::POS_W-1:0]          position;

  modport source (output valid, output action, output item_value, output position,
                  input ready);
  modport sink (input valid, input action, input item_value, input position,
                output ready);
endinterface

// result channel
interface dqs_out_if;
  logic                               valid;
  logic                               ready;
  logic [dqs_pkg::STAT_W-1:0]         status;
  logic [dqs_pkg::POS_W-1:0]          found_index;
  logic signed [dqs_pkg::VALUE_W-1:0] found_value;

  modport source (output valid, output status, output found_index, output found_value,
                  input ready);
  modport sink (input valid, input status, input found_index, input found_value,
                output ready);
endinterface
`default_nettype wire

// ----- rtl/core/dqs_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dqs_ram
// Generic RAM, one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/core/deque_with_search_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Bounded double-ended queue of 32-bit values held in a ring RAM of DEPTH
// entries with a front pointer and an entry count. A push or pop moves the
// sequencer from idle straight to its finish state on acceptance, and so
// does a find or read on an empty ring, a read at or past the count or an
// unused code. A position read passes a read state first (one RAM read), and
// a find stays in a scan state while it compares entries. The find walks
// the ring one entry per cycle through the single RAM read port and one
// shared slot adder and comparator. In every case the result is loaded into
// the output register as the finish state returns to idle and the request
// side opens, but waits while an untaken result holds the output register. The
// request side takes a new item only when the sequencer is idle; a finished
// result sits there until taken, and the next item may be accepted meanwhile.
// ----------------------------------------------------------------------------
// deque_with_search_unit
// Ring-store deque with push/pop at both ends, linear find and position read.
// ----------------------------------------------------------------------------
module deque_with_search_unit (
  input  wire logic  clk,
  input  wire logic  rst_n,
  dqs_in_if.sink     in_ch,
  dqs_out_if.source  out_ch
);

  localparam int PTR_W = dqs_pkg::PTR_W;
  localparam int CNT_W = dqs_pkg::CNT_W;
  localparam int SUM_W = dqs_pkg::SUM_W;
  localparam int VW    = dqs_pkg::VALUE_W;
  localparam int PW    = dqs_pkg::POS_W;

  dqs_pkg::state_t      state_r, state_nxt;
  logic [PTR_W-1:0]     front_r, front_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [PTR_W-1:0]     cur_r, cur_nxt;
  logic [VW-1:0]        val_r, val_nxt;
  dqs_pkg::status_t     res_status_r, res_status_nxt;
  logic [PW-1:0]        res_idx_r, res_idx_nxt;
  logic [VW-1:0]        res_value_r, res_value_nxt;

  logic                 out_valid_r;
  logic [dqs_pkg::STAT_W-1:0] out_status_r;
  logic [PW-1:0]        out_idx_r;
  logic [VW-1:0]        out_value_r;

  logic                 acc;
  logic                 is_full;
  logic                 is_empty;
  logic                 pos_ok;
  logic                 hit;
  logic                 last;
  logic                 out_free;
  logic [31:0]          pos_ext;
  logic [31:0]          cur_ext;
  logic [PTR_W-1:0]     off;
  logic [SUM_W-1:0]     sum;
  logic [PTR_W-1:0]     slot;
  dqs_pkg::action_t     act;

  logic                 ram_we;
  logic [PTR_W-1:0]     ram_waddr;
  logic [VW-1:0]        ram_wdata;
  logic [PTR_W-1:0]     ram_raddr;
  logic [VW-1:0]        ram_rdata;

  // request decode and flags
  assign act      = dqs_pkg::action_t'(in_ch.action);
  assign acc      = in_ch.valid && in_ch.ready;
  assign is_full  = 32'(count_r) == dqs_pkg::DEPTH;
  assign is_empty = count_r == '0;
  assign pos_ext  = 32'(in_ch.position);
  assign cur_ext  = 32'(cur_r);
  assign pos_ok   = pos_ext < 32'(count_r);
  assign hit      = ram_rdata == val_r;
  assign last     = (cur_ext + 32'd1) >= 32'(count_r);
  assign out_free = !out_valid_r || out_ch.ready;

  // offset select for the shared slot adder
  always_comb begin
    off = '0;
    unique case (state_r)
      dqs_pkg::S_IDLE: begin
        unique case (act)
          dqs_pkg::ACT_PUSH_FRONT: off = PTR_W'(dqs_pkg::DEPTH - 1);
          dqs_pkg::ACT_PUSH_BACK:  off = count_r[PTR_W-1:0];
          dqs_pkg::ACT_POP_FRONT:  off = PTR_W'(1);
          dqs_pkg::ACT_READ_POS:   off = pos_ext[PTR_W-1:0];
          default:                 off = '0;
        endcase
      end
      dqs_pkg::S_SCAN: off = cur_r + PTR_W'(1);
      default:         off = '0;
    endcase
  end

  // shared slot adder: front plus offset, wrapped at the ring size
  always_comb begin
    sum  = {1'b0, front_r} + {1'b0, off};
    slot = (sum >= SUM_W'(dqs_pkg::DEPTH)) ? PTR_W'(sum - SUM_W'(dqs_pkg::DEPTH))
                                           : sum[PTR_W-1:0];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dqs_pkg::S_IDLE: begin
        if (acc) begin
          unique case (act)
            dqs_pkg::ACT_FIND:     state_nxt = is_empty ? dqs_pkg::S_FIN : dqs_pkg::S_SCAN;
            dqs_pkg::ACT_READ_POS: state_nxt = (is_empty || !pos_ok) ? dqs_pkg::S_FIN
                                                                     : dqs_pkg::S_READ;
            default:               state_nxt = dqs_pkg::S_FIN;
          endcase
        end
      end
      dqs_pkg::S_READ: state_nxt = dqs_pkg::S_FIN;
      dqs_pkg::S_SCAN: state_nxt = (hit || last) ? dqs_pkg::S_FIN : dqs_pkg::S_SCAN;
      dqs_pkg::S_FIN:  state_nxt = out_free ? dqs_pkg::S_IDLE : dqs_pkg::S_FIN;
      default:         state_nxt = dqs_pkg::S_IDLE;
    endcase
  end

  // pointer, count, scan and result updates
  always_comb begin
    front_nxt      = front_r;
    count_nxt      = count_r;
    cur_nxt        = cur_r;
    val_nxt        = val_r;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;
    res_value_nxt  = res_value_r;
    unique case (state_r)
      dqs_pkg::S_IDLE: begin
        if (acc) begin
          val_nxt        = in_ch.item_value;
          cur_nxt        = '0;
          res_status_nxt = dqs_pkg::ST_DONE;
          res_idx_nxt    = '0;
          res_value_nxt  = '0;
          unique case (act)
            dqs_pkg::ACT_PUSH_FRONT: begin
              if (is_full) begin
                res_status_nxt = dqs_pkg::ST_FULL;
              end else begin
                front_nxt = slot;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            dqs_pkg::ACT_PUSH_BACK: begin
              if (is_full) begin
                res_status_nxt = dqs_pkg::ST_FULL;
              end else begin
                count_nxt = count_r + CNT_W'(1);
              end
            end
            dqs_pkg::ACT_POP_FRONT: begin
              if (is_empty) begin
                res_status_nxt = dqs_pkg::ST_EMPTY;
              end else begin
                front_nxt = slot;
                count_nxt = count_r - CNT_W'(1);
              end
            end
            dqs_pkg::ACT_POP_BACK: begin
              if (is_empty) begin
                res_status_nxt = dqs_pkg::ST_EMPTY;
              end else begin
                count_nxt = count_r - CNT_W'(1);
              end
            end
            dqs_pkg::ACT_FIND: begin
              if (is_empty) begin
                res_status_nxt = dqs_pkg::ST_EMPTY;
              end
            end
            dqs_pkg::ACT_READ_POS: begin
              if (is_empty) begin
                res_status_nxt = dqs_pkg::ST_EMPTY;
              end else if (!pos_ok) begin
                res_status_nxt = dqs_pkg::ST_NOT_FOUND;
              end else begin
                res_idx_nxt = in_ch.position;
              end
            end
            default: ;
          endcase
        end
      end
      dqs_pkg::S_READ: begin
        res_value_nxt = ram_rdata;
      end
      dqs_pkg::S_SCAN: begin
        if (hit) begin
          res_status_nxt = dqs_pkg::ST_DONE;
          res_idx_nxt    = cur_ext[PW-1:0];
          res_value_nxt  = val_r;
        end else if (last) begin
          res_status_nxt = dqs_pkg::ST_NOT_FOUND;
        end else begin
          cur_nxt = cur_r + PTR_W'(1);
        end
      end
      default: ;
    endcase
  end

  // outputs to the ram and the request side
  always_comb begin
    in_ch.ready = state_r == dqs_pkg::S_IDLE;
    ram_we      = acc && !is_full &&
                  (act == dqs_pkg::ACT_PUSH_FRONT || act == dqs_pkg::ACT_PUSH_BACK);
    ram_waddr   = slot;
    ram_wdata   = in_ch.item_value;
    ram_raddr   = slot;
  end

  // control and working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dqs_pkg::S_IDLE;
      front_r <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      front_r <= front_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    val_r        <= val_nxt;
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    res_value_r  <= res_value_nxt;
  end

  // result output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == dqs_pkg::S_FIN && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == dqs_pkg::S_FIN && out_free) begin
      out_status_r <= res_status_r;
      out_idx_r    <= res_idx_r;
      out_value_r  <= res_value_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.found_index = out_idx_r;
  assign out_ch.found_value = out_value_r;

  // ring store
  dqs_ram #(
    .WIDTH (VW),
    .DEPTH (dqs_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // count never passes the ring size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= dqs_pkg::DEPTH)
    else $error("entry count beyond ring size");

  // scan index stays inside the held entries
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == dqs_pkg::S_SCAN |-> cur_ext < 32'(count_r))
    else $error("scan index past entry count");

  // a scan leaves front and count alone
  a_scan_stable: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == dqs_pkg::S_SCAN |=> $stable(count_r) && $stable(front_r))
    else $error("ring changed during scan");

  // a push into a full ring changes nothing
  a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
    acc && is_full &&
    (act == dqs_pkg::ACT_PUSH_FRONT || act == dqs_pkg::ACT_PUSH_BACK)
    |=> $stable(count_r) && $stable(front_r) && res_status_r == dqs_pkg::ST_FULL)
    else $error("push into full ring not ignored");

endmodule
`default_nettype wire

// ----- verif/deque_with_search_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_with_search_checker
// Passive checker for the deque with search unit. It watches the request and
// result channels and tracks the deque contents, front slot and fill level on
// its own. Each accepted result is compared field by field against the oldest
// expected result in a FIFO.
// ----------------------------------------------------------------------------
module deque_with_search_checker (
  input  logic clk,
  input  logic rst_n,
  dqs_in_if    in_ch,
  dqs_out_if   out_ch,
  output int   fail_count,
  output int   outstanding,
  output int   checked
);

  // one result item as the block should return it
  typedef struct packed {
    logic [dqs_pkg::STAT_W-1:0]         status;
    logic [dqs_pkg::POS_W-1:0]          index;
    logic signed [dqs_pkg::VALUE_W-1:0] value;
  } deque_result_t;

  deque_result_t                      pending_results[$];
  logic signed [dqs_pkg::VALUE_W-1:0] ring_mem [dqs_pkg::DEPTH];
  logic [dqs_pkg::PTR_W-1:0]          head_slot;
  int                                 fill_level;

  // ring slot of the entry at a given distance from the front
  function automatic logic [dqs_pkg::PTR_W-1:0] slot_at(input int offset);
    return dqs_pkg::PTR_W'((int'(head_slot) + offset) % dqs_pkg::DEPTH);
  endfunction

  // apply one request to the tracked deque and build its result
  function automatic deque_result_t apply_request(
      input logic [dqs_pkg::ACT_W-1:0] act,
      input logic signed [dqs_pkg::VALUE_W-1:0] val,
      input logic [dqs_pkg::POS_W-1:0] pos);
    deque_result_t res;
    bit            hit;
    res = '0;
    res.status = dqs_pkg::ST_DONE;
    hit = 1'b0;
    case (act)
      dqs_pkg::ACT_PUSH_FRONT: begin
        if (fill_level >= dqs_pkg::DEPTH) begin
          res.status = dqs_pkg::ST_FULL;
        end else begin
          head_slot = slot_at(dqs_pkg::DEPTH - 1);
          ring_mem[head_slot] = val;
          fill_level++;
        end
      end
      dqs_pkg::ACT_PUSH_BACK: begin
        if (fill_level >= dqs_pkg::DEPTH) begin
          res.status = dqs_pkg::ST_FULL;
        end else begin
          ring_mem[slot_at(fill_level)] = val;
          fill_level++;
        end
      end
      dqs_pkg::ACT_POP_FRONT: begin
        if (fill_level == 0) begin
          res.status = dqs_pkg::ST_EMPTY;
        end else begin
          head_slot = slot_at(1);
          fill_level--;
        end
      end
      dqs_pkg::ACT_POP_BACK: begin
        if (fill_level == 0) res.status = dqs_pkg::ST_EMPTY;
        else fill_level--;
      end
      dqs_pkg::ACT_FIND: begin
        if (fill_level == 0) begin
          res.status = dqs_pkg::ST_EMPTY;
        end else begin
          res.status = dqs_pkg::ST_NOT_FOUND;
          // first match from the front wins
          for (int i = 0; i < fill_level; i++) begin
            if (!hit && ring_mem[slot_at(i)] == val) begin
              hit = 1'b1;
              res.status = dqs_pkg::ST_DONE;
              res.index = dqs_pkg::POS_W'(i);
              res.value = val;
            end
          end
        end
      end
      dqs_pkg::ACT_READ_POS: begin
        if (fill_level == 0) begin
          res.status = dqs_pkg::ST_EMPTY;
        end else if (int'(pos) >= fill_level) begin
          res.status = dqs_pkg::ST_NOT_FOUND;
        end else begin
          res.index = pos;
          res.value = ring_mem[slot_at(int'(pos))];
        end
      end
      default: ; // unused codes leave the deque alone and report done
    endcase
    return res;
  endfunction

  // report one field mismatch
  function automatic void report_mismatch(input string field,
                                          input logic [dqs_pkg::VALUE_W-1:0] want,
                                          input logic [dqs_pkg::VALUE_W-1:0] got);
    $error("%s: expected %0h, actual %0h", field, want, got);
  endfunction

  // sample both channels at each edge and update the tracked state
  always @(posedge clk) begin
    deque_result_t want;
    int            errs;
    errs = 0;
    if (!rst_n) begin
      head_slot = '0;
      fill_level = 0;
      pending_results.delete();
      fail_count <= 0;
      outstanding <= 0;
      checked <= 0;
    end else begin
      // compare first so a new request never pairs with an older result
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("result item with nothing expected: status %0d index %0d value %0h",
                 out_ch.status, out_ch.found_index, out_ch.found_value);
          errs++;
        end else begin
          want = pending_results.pop_front();
          if (out_ch.status !== want.status) begin
            report_mismatch("status", dqs_pkg::VALUE_W'(want.status),
                            dqs_pkg::VALUE_W'(out_ch.status));
            errs++;
          end
          if (out_ch.found_index !== want.index) begin
            report_mismatch("found_index", dqs_pkg::VALUE_W'(want.index),
                            dqs_pkg::VALUE_W'(out_ch.found_index));
            errs++;
          end
          if (out_ch.found_value !== want.value) begin
            report_mismatch("found_value", want.value, out_ch.found_value);
            errs++;
          end
        end
        checked <= checked + 1;
      end
      if (in_ch.valid && in_ch.ready)
        pending_results.push_back(apply_request(in_ch.action, in_ch.item_value,
                                                in_ch.position));
      outstanding <= pending_results.size();
      fail_count <= fail_count + errs;
    end
  end

endmodule

// ----- verif/deque_with_search_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_with_search_unit_tb
// Drives request items into the deque with search unit: a directed pass over
// the empty and full corners, then random segments biased toward filling,
// draining or querying, with random gaps and result back-pressure. A checker
// instance predicts and compares every result item.
// ----------------------------------------------------------------------------
module deque_with_search_unit_tb;
  import dqs_pkg::*;

  // codes outside the defined request set
  localparam logic [ACT_W-1:0] ACT_UNUSED_LO = 3'd6;
  localparam logic [ACT_W-1:0] ACT_UNUSED_HI = 3'd7;
  localparam int               RANDOM_ITEMS  = 1350;

  typedef enum int {SEG_FILL, SEG_DRAIN, SEG_QUERY, SEG_MIXED} segment_t;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   outstanding;
  int   checked;
  bit   steady;

  int n_push, n_pop, n_find, n_read, n_unused;
  logic signed [VALUE_W-1:0] recent_values [8];
  int recent_wr;

  dqs_in_if  in_ch ();
  dqs_out_if out_ch ();

  deque_with_search_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  deque_with_search_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding),
    .checked     (checked)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // run limit
  initial begin
    #3_000_000;
    $display("timeout with %0d results still expected", outstanding);
    $display("== FAIL ==");
    $finish;
  end

  // idle cycles before an item, none during a steady stretch
  function automatic int pick_gap();
    return steady ? 0 : $urandom_range(0, 19);
  endfunction

  // data value: small values repeat so finds hit, plus full-range and extremes
  function automatic logic signed [VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return VALUE_W'($urandom_range(0, 15));
    if (r < 60) return $urandom;
    if (r < 72) begin
      case ($urandom_range(0, 3))
        0:       return 32'sh7fff_ffff;
        1:       return 32'sh8000_0000;
        2:       return -32'sd1;
        default: return 32'sd0;
      endcase
    end
    return recent_values[$urandom_range(0, 7)];
  endfunction

  // request code weighted by the kind of segment
  function automatic logic [ACT_W-1:0] pick_action(input segment_t kind);
    int r;
    int push_w, pop_w, find_w;
    r = $urandom_range(0, 99);
    case (kind)
      SEG_FILL:  begin push_w = 65; pop_w = 10; find_w = 14; end
      SEG_DRAIN: begin push_w = 15; pop_w = 60; find_w = 14; end
      SEG_QUERY: begin push_w = 20; pop_w = 15; find_w = 34; end
      default:   begin push_w = 35; pop_w = 35; find_w = 14; end
    endcase
    if (r == 99) return $urandom_range(0, 1) ? ACT_UNUSED_HI : ACT_UNUSED_LO;
    if (r < push_w) return $urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
    if (r < push_w + pop_w) return $urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT;
    if (r < push_w + pop_w + find_w) return ACT_FIND;
    return ACT_READ_POS;
  endfunction

  // present one request item and hold it until accepted
  task automatic send_request(input logic [ACT_W-1:0] act,
                              input logic signed [VALUE_W-1:0] val,
                              input logic [POS_W-1:0] pos);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.action     <= act;
    in_ch.item_value <= val;
    in_ch.position   <= pos;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    case (act)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        n_push++;
        recent_values[recent_wr] = val;
        recent_wr = (recent_wr + 1) % 8;
      end
      ACT_POP_FRONT, ACT_POP_BACK: n_pop++;
      ACT_FIND:                    n_find++;
      ACT_READ_POS:                n_read++;
      default:                     n_unused++;
    endcase
  endtask

  // result side: random stall before taking each result item
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  // reset, directed corners, random segments, drain and verdict
  initial begin
    segment_t         kind;
    logic [ACT_W-1:0] act;
    logic signed [VALUE_W-1:0] val;
    int               seg_len;
    int               random_sent;
    n_push = 0; n_pop = 0; n_find = 0; n_read = 0; n_unused = 0;
    recent_wr = 0;
    for (int i = 0; i < 8; i++) recent_values[i] = VALUE_W'(i);
    steady = 1'b0;
    rst_n <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.action     <= ACT_PUSH_BACK;
    in_ch.item_value <= '0;
    in_ch.position   <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // everything on an empty deque
    send_request(ACT_POP_FRONT, 32'sd5, 4'd0);
    send_request(ACT_POP_BACK, 32'sd5, 4'd0);
    send_request(ACT_FIND, 32'sd0, 4'd0);
    send_request(ACT_READ_POS, 32'sd0, 4'd0);
    // extremes at both ends, front push wraps the ring
    send_request(ACT_PUSH_FRONT, 32'sh7fff_ffff, 4'd0);
    send_request(ACT_PUSH_BACK, 32'sh8000_0000, 4'd0);
    send_request(ACT_PUSH_BACK, -32'sd1, 4'd0);
    send_request(ACT_PUSH_FRONT, 32'sd0, 4'd0);
    // find hit, find miss, read inside and at the fill level
    send_request(ACT_FIND, 32'sh8000_0000, 4'd15);
    send_request(ACT_FIND, 32'sd12345, 4'd0);
    send_request(ACT_READ_POS, 32'sd0, 4'd2);
    send_request(ACT_READ_POS, 32'sd0, 4'd4);
    send_request(ACT_UNUSED_LO, -32'sd1, 4'd15);
    send_request(ACT_UNUSED_HI, 32'sd0, 4'd0);
    // fill up, with repeats so find must return the first match
    for (int i = 0; i < 12; i++) send_request(ACT_PUSH_BACK, VALUE_W'(i % 3), 4'd0);
    send_request(ACT_READ_POS, 32'sd0, 4'd15);
    send_request(ACT_PUSH_FRONT, 32'sd77, 4'd0);
    send_request(ACT_POP_FRONT, 32'sd0, 4'd0);
    send_request(ACT_POP_BACK, 32'sd0, 4'd0);

    // random segments
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      kind = segment_t'($urandom_range(0, 3));
      steady = ($urandom_range(0, 3) == 0);
      seg_len = $urandom_range(8, 40);
      repeat (seg_len) begin
        act = pick_action(kind);
        val = (act == ACT_FIND && $urandom_range(0, 9) < 6) ?
              recent_values[$urandom_range(0, 7)] : pick_value();
        send_request(act, val, POS_W'($urandom_range(0, 15)));
        if (act != ACT_UNUSED_LO && act != ACT_UNUSED_HI) random_sent++;
      end
    end
    steady = 1'b0;
    in_ch.valid <= 1'b0;

    // wait for every expected result, then a little longer for strays
    do @(posedge clk); while (outstanding != 0);
    repeat (DEPTH + 8) @(posedge clk);

    $display("requests: %0d pushes, %0d pops, %0d finds, %0d reads, %0d unused codes",
             n_push, n_pop, n_find, n_read, n_unused);
    $display("results checked: %0d, mismatches: %0d", checked, fail_count);
    if (fail_count == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/dqs_pkg.sv
rtl/core/dqs_if.sv
rtl/core/dqs_ram.sv
rtl/core/deque_with_search_unit.sv
verif/deque_with_search_checker.sv
verif/deque_with_search_unit_tb.sv
